// File: design/snr_per_table_interpolator_assert.svh
// Assertion macros for the SNR/PER table interpolator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SNR_PER_TABLE_INTERPOLATOR_ASSERT_SVH
`define SNR_PER_TABLE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication under reset.
`define SNRPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("snrpt same-cycle check failed");

// Next-cycle implication under reset.
`define SNRPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("snrpt next-cycle check failed");

`endif

// File: design/snrpt_pkg.sv
// Shared types and constants of the SNR/PER table interpolator.
// No dependencies; imported by the divider, the top level and the bench.
`timescale 1ns / 1ps

package snrpt_pkg;

  // Request and status codes
  localparam logic       REQ_LOAD  = 1'b0;
  localparam logic       REQ_QUERY = 1'b1;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BELOW  = 2'd1;
  localparam logic [1:0] ST_ABOVE  = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Shared divider widths: dividend and divisor
  localparam int DIV_NW = 45;
  localparam int DIV_DW = 17;

  typedef struct packed {
    logic              req_type;
    logic [1:0]        mod_class;
    logic              size_sel;
    logic [3:0]        mcs;
    logic [5:0]        point_index;
    logic              point_last;
    logic signed [15:0] snr_centidb;
    logic [16:0]       per_q16;
    logic [15:0]       frame_bytes;
  } in_t;

  typedef struct packed {
    logic [16:0] success_q16;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  // Q30 factors 2^(-2^-j) for j = 1..24, entry 0 holds j = 1
  typedef logic [23:0][30:0] exp_tab_t;

  function automatic exp_tab_t exp_table();
    exp_tab_t    tab;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    c = 64'd1 << 29;
    for (int j = 0; j < 24; j++) begin
      v   = c << 30;
      res = '0;
      bt  = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      c      = res;
      tab[j] = c[30:0];
    end
    return tab;
  endfunction

endpackage

// File: design/snrpt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module snrpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/snrpt_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on snrpt_pkg for widths and request/response structs.
`timescale 1ns / 1ps

module snrpt_div import snrpt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNTW = $clog2(DIV_NW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dvs_r, dvs_nxt;
  logic [DIV_DW:0]   trial;

  assign trial = {rem_r, quo_r[DIV_NW-1]};

  // Shift in one dividend bit and try the subtract
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_DW'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

// File: design/snr_per_table_interpolator.sv
// Top level of the SNR/PER table interpolator: sequencer, shared multiplier,
// point and count memories. Depends on snrpt_pkg, snrpt_ram, snrpt_div.
//
// Usage:
//   in_* beats carry either a table point (load) or a query. A load writes
//   one point and gives no result. A query picks a table,
//   scans its points, interpolates, and scales the success rate to the
//   frame length; it yields one out_* beat (success_q16, status).
//   in_stall is high while a query is in progress.
// Query sequence:
//   Count read, then the point scan (n points, one memory read per cycle),
//   then, where needed, a divide for interpolation, the normalize steps,
//   24 squaring steps, another divide and 24 exponent steps on the shared
//   multiplier. The divider is bit-serial and there is a single multiplier;
//   a new beat is not taken until the query is done.
// Reset:
//   Synchronous, active low. All table counts read as zero afterwards;
//   point memories hold no reset value and need no clearing pass.
// Output stall:
//   A finished query waits in S_OUT until the output register is free (empty
//   or out_stall low); the result then waits there while out_stall is high.
//   The block may accept loads meanwhile only once it is back in idle.
`timescale 1ns / 1ps

`include "snr_per_table_interpolator_assert.svh"

module snr_per_table_interpolator import snrpt_pkg::*; #(
  parameter int MAX_POINTS       = 64,
  parameter int MCS_COUNT        = 12,
  parameter int SMALL_REF_BYTES  = 32,
  parameter int LARGE_REF_BYTES  = 1458,
  parameter int SIZE_SPLIT_BYTES = 400
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int NUM_TABLES = 8 * MCS_COUNT;
  localparam int NUM_PTS    = NUM_TABLES * MAX_POINTS;
  localparam int TW         = $clog2(NUM_TABLES);
  localparam int AW         = $clog2(NUM_PTS);
  localparam int CW         = $clog2(MAX_POINTS + 1);
  localparam int PW         = 33;

  localparam exp_tab_t EXP_C = exp_table();

  // Sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CNT   = 5'd1;
  localparam logic [4:0] S_CNTW  = 5'd2;
  localparam logic [4:0] S_SCAN  = 5'd3;
  localparam logic [4:0] S_DEC   = 5'd4;
  localparam logic [4:0] S_IMUL  = 5'd5;
  localparam logic [4:0] S_IDIVS = 5'd6;
  localparam logic [4:0] S_IDIVW = 5'd7;
  localparam logic [4:0] S_SCALE = 5'd8;
  localparam logic [4:0] S_NORM  = 5'd9;
  localparam logic [4:0] S_SQR   = 5'd10;
  localparam logic [4:0] S_LMUL  = 5'd11;
  localparam logic [4:0] S_YDIVS = 5'd12;
  localparam logic [4:0] S_YDIVW = 5'd13;
  localparam logic [4:0] S_EXP   = 5'd14;
  localparam logic [4:0] S_FIN   = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  logic [4:0] state_r, state_nxt;

  // Query context
  logic signed [15:0] q_r, q_nxt;
  logic [15:0]        fb_r, fb_nxt;
  logic [15:0]        ref_r, ref_nxt;
  logic [TW-1:0]      t_r, t_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic               mcs_ok_r, mcs_ok_nxt;
  logic [CW-1:0]      n_r, n_nxt;

  // Scan state
  logic [CW-1:0]      rd_i_r, rd_i_nxt;
  logic               chk_v_r, chk_v_nxt;
  logic [CW-1:0]      chk_i_r, chk_i_nxt;
  logic               found_r, found_nxt;
  logic               brk_r, brk_nxt;
  logic signed [15:0] snr0_r, snr0_nxt;
  logic signed [15:0] snrl_r, snrl_nxt;
  logic signed [15:0] prev_s_r, prev_s_nxt;
  logic [16:0]        prev_p_r, prev_p_nxt;
  logic signed [15:0] p_r, p_nxt;
  logic signed [15:0] nx_r, nx_nxt;
  logic [16:0]        a_r, a_nxt;
  logic [16:0]        b_r, b_nxt;
  logic [16:0]        per_r, per_nxt;
  logic               sgn_r, sgn_nxt;

  // Log / exp state
  logic [15:0]        s_r, s_nxt;
  logic [3:0]         k_r, k_nxt;
  logic [30:0]        x_r, x_nxt;
  logic [23:0]        frac_r, frac_nxt;
  logic [4:0]         it_r, it_nxt;
  logic [DIV_NW-1:0]  y_r, y_nxt;
  logic [30:0]        acc_r, acc_nxt;

  // Divider operands and result
  logic [DIV_NW-1:0]  dvd_r, dvd_nxt;
  logic [DIV_DW-1:0]  dvs_r, dvs_nxt;
  logic [16:0]        res_succ_r, res_succ_nxt;
  logic [1:0]         res_stat_r, res_stat_nxt;

  logic               out_valid_r;
  out_t               out_data_r;
  logic               out_load;

  // Memories and shared units
  logic               pt_we;
  logic [AW-1:0]      pt_waddr;
  logic [PW-1:0]      pt_wdata;
  logic [AW-1:0]      pt_raddr;
  logic [PW-1:0]      pt_rdata;
  logic               cnt_we;
  logic [TW-1:0]      cnt_waddr;
  logic [CW-1:0]      cnt_wdata;
  logic [CW-1:0]      cnt_rdata;
  logic [NUM_TABLES-1:0] cnt_vld_r;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // Input-side decode
  logic               acc_beat;
  logic [TW-1:0]      t_ld;
  logic [1:0]         q_cls;
  logic               q_ssel;
  logic [16:0]        per_clip;

  // Scan datapath
  logic signed [15:0] d_s;
  logic [16:0]        d_p;

  // Interpolation datapath
  logic signed [16:0] d_qp;
  logic signed [17:0] d_ba;
  logic signed [16:0] den;
  logic [16:0]        qp_mag;
  logic [17:0]        ba_mag;
  logic signed [46:0] v_sum;
  logic [16:0]        s_val;
  logic [31:0]        sq_t;
  logic [28:0]        l_val;
  logic [5:0]         ip6;
  logic [63:0]        fin_sum;
  logic [63:0]        fin_shr;

  assign acc_beat = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  snrpt_ram #(.WIDTH(PW), .DEPTH(NUM_PTS)) u_pt_ram (
    .clk     (clk),
    .wr_en   (pt_we),
    .wr_addr (pt_waddr),
    .wr_data (pt_wdata),
    .rd_addr (pt_raddr),
    .rd_data (pt_rdata)
  );

  snrpt_ram #(.WIDTH(CW), .DEPTH(NUM_TABLES)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_data (cnt_wdata),
    .rd_addr (t_r),
    .rd_data (cnt_rdata)
  );

  snrpt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Load path: write one point, set the count on the last point
  assign t_ld = TW'(int'({in_data.mod_class, in_data.size_sel}) * MCS_COUNT
                + int'(in_data.mcs));
  assign per_clip  = (in_data.per_q16 > ONE_Q16) ? ONE_Q16 : in_data.per_q16;
  assign pt_we     = acc_beat && (in_data.req_type == REQ_LOAD)
                     && (int'(in_data.mcs) < MCS_COUNT)
                     && (int'(in_data.point_index) < MAX_POINTS);
  assign pt_waddr  = AW'(int'(t_ld) * MAX_POINTS + int'(in_data.point_index));
  assign pt_wdata  = {in_data.snr_centidb, per_clip};
  assign cnt_we    = pt_we && in_data.point_last;
  assign cnt_waddr = t_ld;
  assign cnt_wdata = CW'(int'(in_data.point_index) + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (cnt_we) begin
      cnt_vld_r[t_ld] <= 1'b1;
    end
  end

  // Query table choice
  always_comb begin
    if (in_data.frame_bytes == 16'(SMALL_REF_BYTES)) begin
      q_cls  = in_data.mod_class;
      q_ssel = 1'b0;
    end else if (in_data.frame_bytes == 16'(LARGE_REF_BYTES)) begin
      q_cls  = in_data.mod_class;
      q_ssel = 1'b1;
    end else begin
      q_cls  = (in_data.mod_class == 2'd0) ? 2'd0 : 2'd1;
      q_ssel = !(in_data.frame_bytes < 16'(SIZE_SPLIT_BYTES));
    end
  end

  assign pt_raddr = base_r + AW'(rd_i_r);
  assign d_s      = signed'(pt_rdata[32:17]);
  assign d_p      = pt_rdata[16:0];

  // Interpolation operands
  assign d_qp   = {q_r[15], q_r} - {p_r[15], p_r};
  assign d_ba   = signed'({1'b0, b_r}) - signed'({1'b0, a_r});
  assign den    = {nx_r[15], nx_r} - {p_r[15], p_r};
  assign qp_mag = d_qp[16] ? 17'(-d_qp) : 17'(d_qp);
  assign ba_mag = d_ba[17] ? 18'(-d_ba) : 18'(d_ba);
  assign v_sum  = sgn_r ? (signed'({30'b0, a_r}) - signed'({2'b0, div_rsp.quot}))
                        : (signed'({30'b0, a_r}) + signed'({2'b0, div_rsp.quot}));
  assign s_val  = ONE_Q16 - per_r;
  assign sq_t   = mul_p[61:30];
  assign l_val  = {5'(k_r) + 5'd1, 24'b0} - {5'b0, frac_r};
  assign ip6    = y_r[29:24];
  assign fin_sum = {33'b0, acc_r} + (64'd1 << (6'd13 + ip6));
  assign fin_shr = fin_sum >> (6'd14 + ip6);

  // Shared multiplier
  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  assign div_req.start    = (state_r == S_IDIVS) || (state_r == S_YDIVS);
  assign div_req.dividend = dvd_r;
  assign div_req.divisor  = dvs_r;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    q_nxt        = q_r;
    fb_nxt       = fb_r;
    ref_nxt      = ref_r;
    t_nxt        = t_r;
    base_nxt     = base_r;
    mcs_ok_nxt   = mcs_ok_r;
    n_nxt        = n_r;
    rd_i_nxt     = rd_i_r;
    chk_v_nxt    = chk_v_r;
    chk_i_nxt    = chk_i_r;
    found_nxt    = found_r;
    brk_nxt      = brk_r;
    snr0_nxt     = snr0_r;
    snrl_nxt     = snrl_r;
    prev_s_nxt   = prev_s_r;
    prev_p_nxt   = prev_p_r;
    p_nxt        = p_r;
    nx_nxt       = nx_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    per_nxt      = per_r;
    sgn_nxt      = sgn_r;
    s_nxt        = s_r;
    k_nxt        = k_r;
    x_nxt        = x_r;
    frac_nxt     = frac_r;
    it_nxt       = it_r;
    y_nxt        = y_r;
    acc_nxt      = acc_r;
    dvd_nxt      = dvd_r;
    dvs_nxt      = dvs_r;
    res_succ_nxt = res_succ_r;
    res_stat_nxt = res_stat_r;
    mul_a        = '0;
    mul_b        = '0;

    case (state_r)
      S_IDLE: begin
        // Capture a query beat
        if (in_valid && (in_data.req_type == REQ_QUERY)) begin
          q_nxt      = in_data.snr_centidb;
          fb_nxt     = in_data.frame_bytes;
          ref_nxt    = q_ssel ? 16'(LARGE_REF_BYTES) : 16'(SMALL_REF_BYTES);
          mcs_ok_nxt = (int'(in_data.mcs) < MCS_COUNT);
          t_nxt      = TW'(int'({q_cls, q_ssel}) * MCS_COUNT + int'(in_data.mcs));
          base_nxt   = AW'((int'({q_cls, q_ssel}) * MCS_COUNT + int'(in_data.mcs))
                       * MAX_POINTS);
          state_nxt  = S_CNT;
        end
      end
      S_CNT: begin
        state_nxt = S_CNTW;
      end
      S_CNTW: begin
        n_nxt     = (mcs_ok_r && cnt_vld_r[t_r]) ? cnt_rdata : '0;
        rd_i_nxt  = '0;
        chk_v_nxt = 1'b0;
        found_nxt = 1'b0;
        brk_nxt   = 1'b0;
        if (!(mcs_ok_r && cnt_vld_r[t_r]) || (cnt_rdata == '0)) begin
          res_succ_nxt = '0;
          res_stat_nxt = ST_EMPTY;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one read per cycle
        if (rd_i_r < n_r) begin
          rd_i_nxt  = rd_i_r + 1'b1;
          chk_v_nxt = 1'b1;
          chk_i_nxt = rd_i_r;
        end else begin
          chk_v_nxt = 1'b0;
        end
        // Check the point read last cycle
        if (chk_v_r) begin
          if (!found_r && (d_s == q_r)) begin
            found_nxt = 1'b1;
            per_nxt   = d_p;
          end
          if (chk_i_r == '0) begin
            snr0_nxt = d_s;
          end
          if (chk_i_r == n_r - 1'b1) begin
            snrl_nxt = d_s;
          end
          if ((chk_i_r != '0) && !brk_r && (d_s > q_r)) begin
            brk_nxt = 1'b1;
            p_nxt   = prev_s_r;
            a_nxt   = prev_p_r;
            nx_nxt  = d_s;
            b_nxt   = d_p;
          end
          prev_s_nxt = d_s;
          prev_p_nxt = d_p;
        end else if (rd_i_r == n_r) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (found_r) begin
          state_nxt = S_SCALE;
        end else if (q_r < snr0_r) begin
          res_succ_nxt = '0;
          res_stat_nxt = ST_BELOW;
          state_nxt    = S_OUT;
        end else if (q_r > snrl_r) begin
          res_succ_nxt = ONE_Q16;
          res_stat_nxt = ST_ABOVE;
          state_nxt    = S_OUT;
        end else if (den[16] || (den == '0)) begin
          per_nxt   = a_r;
          state_nxt = S_SCALE;
        end else begin
          state_nxt = S_IMUL;
        end
      end
      S_IMUL: begin
        // Product magnitude, then rounding offset for the divide
        mul_a     = 32'(qp_mag);
        mul_b     = 32'(ba_mag);
        sgn_nxt   = d_qp[16] ^ d_ba[17];
        dvd_nxt   = {mul_p[43:0], 1'b0} + {28'b0, den};
        dvs_nxt   = {den[15:0], 1'b0};
        state_nxt = S_IDIVS;
      end
      S_IDIVS: begin
        state_nxt = S_IDIVW;
      end
      S_IDIVW: begin
        if (div_rsp.done) begin
          if (v_sum[46]) begin
            per_nxt = '0;
          end else if (v_sum > 47'sd65536) begin
            per_nxt = ONE_Q16;
          end else begin
            per_nxt = v_sum[16:0];
          end
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if ((fb_r == ref_r) || (s_val == '0) || (s_val == ONE_Q16)) begin
          res_succ_nxt = s_val;
          res_stat_nxt = ST_OK;
          state_nxt    = S_OUT;
        end else begin
          s_nxt     = s_val[15:0];
          k_nxt     = '0;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        // Normalize one bit per cycle
        if (!s_r[15]) begin
          s_nxt = {s_r[14:0], 1'b0};
          k_nxt = k_r + 1'b1;
        end else begin
          x_nxt     = {s_r, 15'b0};
          frac_nxt  = '0;
          it_nxt    = '0;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        // Square the mantissa; each step yields one log fraction bit
        mul_a    = 32'(x_r);
        mul_b    = 32'(x_r);
        frac_nxt = {frac_r[22:0], sq_t[31]};
        x_nxt    = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
        it_nxt   = it_r + 1'b1;
        if (it_r == 5'd23) begin
          state_nxt = S_LMUL;
        end
      end
      S_LMUL: begin
        mul_a     = 32'(l_val);
        mul_b     = 32'(fb_r);
        dvd_nxt   = mul_p[DIV_NW-1:0];
        dvs_nxt   = DIV_DW'(ref_r);
        state_nxt = S_YDIVS;
      end
      S_YDIVS: begin
        state_nxt = S_YDIVW;
      end
      S_YDIVW: begin
        if (div_rsp.done) begin
          y_nxt = div_rsp.quot;
          if (div_rsp.quot[DIV_NW-1:24] >= 21'd40) begin
            res_succ_nxt = '0;
            res_stat_nxt = ST_OK;
            state_nxt    = S_OUT;
          end else begin
            acc_nxt   = 31'd1 << 30;
            it_nxt    = '0;
            state_nxt = S_EXP;
          end
        end
      end
      S_EXP: begin
        // Apply one fraction-bit factor per cycle
        mul_a = 32'(acc_r);
        mul_b = 32'(EXP_C[it_r]);
        if (y_r[5'd23 - it_r]) begin
          acc_nxt = mul_p[60:30];
        end
        it_nxt = it_r + 1'b1;
        if (it_r == 5'd23) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_succ_nxt = fin_shr[16:0];
        res_stat_nxt = ST_OK;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    fb_r       <= fb_nxt;
    ref_r      <= ref_nxt;
    t_r        <= t_nxt;
    base_r     <= base_nxt;
    mcs_ok_r   <= mcs_ok_nxt;
    n_r        <= n_nxt;
    rd_i_r     <= rd_i_nxt;
    chk_v_r    <= chk_v_nxt;
    chk_i_r    <= chk_i_nxt;
    found_r    <= found_nxt;
    brk_r      <= brk_nxt;
    snr0_r     <= snr0_nxt;
    snrl_r     <= snrl_nxt;
    prev_s_r   <= prev_s_nxt;
    prev_p_r   <= prev_p_nxt;
    p_r        <= p_nxt;
    nx_r       <= nx_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    per_r      <= per_nxt;
    sgn_r      <= sgn_nxt;
    s_r        <= s_nxt;
    k_r        <= k_nxt;
    x_r        <= x_nxt;
    frac_r     <= frac_nxt;
    it_r       <= it_nxt;
    y_r        <= y_nxt;
    acc_r      <= acc_nxt;
    dvd_r      <= dvd_nxt;
    dvs_r      <= dvs_nxt;
    res_succ_r <= res_succ_nxt;
    res_stat_r <= res_stat_nxt;
  end

  // Output register: load the result beat when the slot is free
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.success_q16 <= res_succ_r;
      out_data_r.status      <= res_stat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `SNRPT_ASSERT_NEXT(a_query_starts, acc_beat && (in_data.req_type == REQ_QUERY), state_r == S_CNT)
  `SNRPT_ASSERT_NEXT(a_result_lands, out_load, out_valid_r && (state_r == S_IDLE))
  `SNRPT_ASSERT_NOW(a_zero_on_miss, out_valid_r && ((out_data_r.status == ST_BELOW) || (out_data_r.status == ST_EMPTY)), out_data_r.success_q16 == '0)

endmodule

// File: bench/tb_top.sv
// Self-checking bench for snr_per_table_interpolator: builds PER tables,
// queries them and compares every result with an in-bench prediction.
// Depends on snrpt_pkg and the design sources only.
`timescale 1ns / 1ps

module tb_top;
  import snrpt_pkg::*;

  localparam int NPTS     = 64;
  localparam int NMCS     = 12;
  localparam int NTAB     = 8 * NMCS;
  localparam int REF_S    = 32;
  localparam int REF_L    = 1458;
  localparam int SPLIT    = 400;
  localparam int N_ITEMS  = 1550;
  localparam int QUIET_AT = 120;
  localparam int WD_LIMIT = 6000;

  typedef struct {
    in_t d;
    bit  drain;
  } pend_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  pend_t pend_q[$];
  out_t  result_q[$];
  int    err_cnt = 0;
  bit    quiet = 1'b0;
  int    in_gap = 0;
  int    out_gap = 0;
  int    idle_cycles = 0;

  // predicted table contents
  logic signed [15:0] tab_snr[NTAB*NPTS];
  logic [16:0]        tab_per[NTAB*NPTS];
  int unsigned        tab_cnt[NTAB];
  longint unsigned    exp_c[25];

  // generator-side view of which points exist
  bit                 gen_wr[NTAB*NPTS];
  int                 gen_snr[NTAB*NPTS];
  int                 gen_n[NTAB];
  int                 built_q[$];

  snr_per_table_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // -log2(s/65536) in Q24
  function automatic longint unsigned log2_loss(int unsigned s);
    int unsigned     k = 0;
    longint unsigned x;
    longint unsigned fr = 0;
    while (s < 32768) begin
      s = s << 1;
      k++;
    end
    x = longint'(s) << 15;
    for (int i = 0; i < 24; i++) begin
      x = (x * x) >> 30;
      fr = fr << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        fr = fr | 1;
      end
    end
    return (longint'(k + 1) << 24) - fr;
  endfunction

  // 2^-y, y in Q24, result Q16
  function automatic int unsigned pow2_neg(longint unsigned y);
    longint unsigned ip = y >> 24;
    longint unsigned g = y & 64'hFFFFFF;
    longint unsigned acc = 64'd1 << 30;
    if (ip >= 40) return 0;
    for (int j = 1; j <= 24; j++)
      if ((g >> (24 - j)) & 1) acc = (acc * exp_c[j]) >> 30;
    return int'((acc + (64'd1 << (13 + ip))) >> (14 + ip));
  endfunction

  function automatic longint rnd_div(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((2 * (-num) + den) / (2 * den));
  endfunction

  // Apply one accepted beat: a load updates the table copy, a query pushes the expected result
  function automatic void apply_beat(in_t b);
    int unsigned     cls = b.mod_class;
    int unsigned     ssel = b.size_sel;
    int unsigned     t, base, n, i, rf, per, s, succ;
    int              q = b.snr_centidb;
    int unsigned     fb = b.frame_bytes;
    bit              hit = 1'b0;
    longint          p, nx, a, c, v;
    out_t            r;
    if (b.req_type == REQ_LOAD) begin
      if (b.mcs >= NMCS) return;
      t = (cls * 2 + ssel) * NMCS + b.mcs;
      tab_snr[t*NPTS + b.point_index] = b.snr_centidb;
      tab_per[t*NPTS + b.point_index] = (b.per_q16 > ONE_Q16) ? ONE_Q16 : b.per_q16;
      if (b.point_last) tab_cnt[t] = b.point_index + 1;
      return;
    end
    if (fb == REF_S) ssel = 0;
    else if (fb == REF_L) ssel = 1;
    else begin
      cls = (cls == 0) ? 0 : 1;
      ssel = (fb < SPLIT) ? 0 : 1;
    end
    rf = ssel ? REF_L : REF_S;
    n = 0;
    t = 0;
    if (b.mcs < NMCS) begin
      t = (cls * 2 + ssel) * NMCS + b.mcs;
      n = tab_cnt[t];
    end
    base = t * NPTS;
    r.success_q16 = '0;
    r.status = ST_EMPTY;
    if (n == 0) begin
      result_q.push_back(r);
      return;
    end
    per = 0;
    for (i = 0; i < n; i++)
      if (tab_snr[base+i] == q) begin
        per = tab_per[base+i];
        hit = 1'b1;
        break;
      end
    if (!hit) begin
      if (q < tab_snr[base]) begin
        r.status = ST_BELOW;
        result_q.push_back(r);
        return;
      end
      if (q > tab_snr[base+n-1]) begin
        r.success_q16 = ONE_Q16;
        r.status = ST_ABOVE;
        result_q.push_back(r);
        return;
      end
      for (i = 1; i < n; i++)
        if (tab_snr[base+i] > q) break;
      if (i >= n) i = n - 1;
      p = tab_snr[base+i-1];
      nx = tab_snr[base+i];
      a = tab_per[base+i-1];
      c = tab_per[base+i];
      v = a;
      if (nx - p > 0) v = a + rnd_div((longint'(q) - p) * (c - a), nx - p);
      if (v < 0) v = 0;
      if (v > 65536) v = 65536;
      per = int'(v);
    end
    s = 65536 - per;
    if (fb == rf || s == 0 || s == 65536) succ = s;
    else succ = pow2_neg((log2_loss(s) * fb) / rf);
    r.success_q16 = succ[16:0];
    r.status = ST_OK;
    result_q.push_back(r);
  endfunction

  // ---------------- stimulus building ----------------
  task automatic put(in_t d);
    pend_t e;
    e.d = d;
    e.drain = 1'b0;
    pend_q.push_back(e);
  endtask

  task automatic put_load(int cls, int ssel, int mcs, int idx, bit last, int snr, int per);
    in_t d;
    int  t;
    d = '0;
    d.req_type = REQ_LOAD;
    d.mod_class = cls;
    d.size_sel = ssel;
    d.mcs = mcs;
    d.point_index = idx;
    d.point_last = last;
    d.snr_centidb = snr;
    d.per_q16 = per;
    d.frame_bytes = $urandom;
    if (mcs < NMCS) begin
      t = (cls * 2 + ssel) * NMCS + mcs;
      gen_wr[t*NPTS + idx] = 1'b1;
      gen_snr[t*NPTS + idx] = snr;
      if (last) gen_n[t] = idx + 1;
    end
    put(d);
  endtask

  task automatic put_query(int cls, int mcs, int snr, int fb);
    in_t d;
    d = $urandom;
    d.req_type = REQ_QUERY;
    d.mod_class = cls;
    d.mcs = mcs;
    d.snr_centidb = snr;
    d.frame_bytes = fb;
    put(d);
  endtask

  // Load a non-decreasing table of n points and record it as built
  task automatic build_table(int cls, int ssel, int mcs, int n);
    int s = int'($urandom_range(0, 50000)) - 25000;
    int per;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) per = $urandom_range(65537, 131071);
      else per = $urandom_range(0, 65536);
      put_load(cls, ssel, mcs, i, i == n - 1, s, per);
      s = s + (($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 600)));
      if (s > 32767) s = 32767;
    end
    built_q.push_back((cls * 2 + ssel) * NMCS + mcs);
  endtask

  task automatic rand_query();
    int t, cls, ssel, mcs, n, snr, fb, r;
    t = built_q[$urandom_range(0, built_q.size() - 1)];
    cls = t / (2 * NMCS);
    ssel = (t / NMCS) % 2;
    mcs = t % NMCS;
    n = gen_n[t];
    r = $urandom_range(0, 9);
    if (n == 0 || r == 0) snr = $urandom_range(0, 65535) - 32768;
    else if (r < 4) snr = gen_snr[t*NPTS + $urandom_range(0, n - 1)];
    else snr = gen_snr[t*NPTS] - 100 +
               int'($urandom_range(0, gen_snr[t*NPTS+n-1] - gen_snr[t*NPTS] + 200));
    if (snr > 32767) snr = 32767;
    if (snr < -32768) snr = -32768;
    r = $urandom_range(0, 9);
    if (r < 3) fb = ssel ? REF_L : REF_S;
    else if (r == 3) fb = $urandom_range(0, 65535);
    else if (ssel == 0) fb = $urandom_range(1, SPLIT - 1);
    else fb = $urandom_range(SPLIT, 3000);
    put_query(cls, mcs, snr, fb);
  endtask

  // Random load; the table count only moves when all lower points exist
  task automatic noise_load();
    int  cls = $urandom_range(0, 3);
    int  ssel = $urandom_range(0, 1);
    int  mcs = $urandom_range(0, 15);
    int  idx = $urandom_range(0, NPTS - 1);
    bit  last = 1'b0;
    bit  ok = 1'b1;
    int  t;
    if (mcs < NMCS && $urandom_range(0, 2) == 0) begin
      t = (cls * 2 + ssel) * NMCS + mcs;
      for (int i = 0; i < idx; i++) if (!gen_wr[t*NPTS + i]) ok = 1'b0;
      last = ok;
    end
    put_load(cls, ssel, mcs, idx, last, $urandom_range(0, 65535), $urandom_range(0, 131071));
  endtask

  task automatic put_drain();
    pend_t e;
    e.d = '0;
    e.drain = 1'b1;
    pend_q.push_back(e);
  endtask

  task automatic fill_stimulus();
    int cnt = 0;
    int r;
    // empty table, then a five-point table hitting the field extremes
    put_query(0, 0, 0, REF_S);
    put_load(0, 0, 0, 0, 0, -32768, 65536);
    put_load(0, 0, 0, 1, 0, -100, 131071);
    put_load(0, 0, 0, 2, 0, 0, 30000);
    put_load(0, 0, 0, 3, 0, 500, 0);
    put_load(0, 0, 0, 4, 1, 32767, 0);
    put_query(0, 0, -32768, REF_S);
    put_query(0, 0, 0, 100);
    put_query(0, 0, 250, REF_S);
    put_query(0, 0, -50, 399);
    put_query(0, 0, 32767, 0);
    // below and above range, plus out-of-range mcs on load and query
    put_load(3, 1, 11, 0, 0, -200, 1000);
    put_load(3, 1, 11, 1, 1, 200, 60000);
    put_load(3, 1, 15, 0, 1, 0, 0);
    put_query(3, 11, -201, REF_L);
    put_query(3, 11, 201, REF_L);
    put_query(3, 11, 0, REF_L);
    put_query(3, 15, 0, REF_L);
    // fallback from the high classes to HT large
    put_load(1, 1, 5, 0, 0, 0, 100);
    put_load(1, 1, 5, 1, 1, 1000, 65000);
    put_query(2, 5, 300, 65535);
    put_query(3, 5, 999, 1000);
    put_query(1, 5, 1, 400);
    put_drain();
    build_table(0, 1, 3, 64);
    build_table(1, 0, 7, 3);
    while (cnt < N_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        r = ($urandom_range(0, 29) == 0) ? NPTS : int'($urandom_range(1, 8));
        build_table($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, NMCS - 1), r);
        cnt += r;
      end else if (r < 88) begin
        rand_query();
        cnt++;
      end else begin
        noise_load();
        cnt++;
      end
      if (cnt % 400 < 2) put_drain();
    end
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!(in_valid && in_stall)) begin
      // beat accepted or channel idle: predict, then pick the next beat
      if (in_valid) apply_beat(in_data);
      if (pend_q.size() < QUIET_AT) quiet = 1'b1;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pend_q.size() != 0 && pend_q[0].drain) begin
        if (result_q.size() == 0) void'(pend_q.pop_front());
        in_valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        in_data <= pend_q.pop_front().d;
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      // check the result beat
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("unexpected result beat: success_q16 %0d status %0d",
                 out_data.success_q16, out_data.status);
          err_cnt++;
        end else begin
          out_t e;
          e = result_q.pop_front();
          if (out_data.success_q16 !== e.success_q16) begin
            $error("success_q16: expected %0d, got %0d", e.success_q16, out_data.success_q16);
            err_cnt++;
          end
          if (out_data.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_data.status);
            err_cnt++;
          end
        end
      end
      // stall in random bursts
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("snr_per_table_interpolator: mismatch");
      $finish;
    end
  end

  initial begin
    longint unsigned c = 64'd1 << 29;
    for (int j = 1; j <= 24; j++) begin
      c = root64(c << 30);
      exp_c[j] = c;
    end
    for (int t = 0; t < NTAB; t++) begin
      tab_cnt[t] = 0;
      gen_n[t] = 0;
    end
    fill_stimulus();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // wait for all beats to go through and all results to drain
    @(posedge clk);
    while (pend_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (result_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("snr_per_table_interpolator: match");
    end else begin
      $display("snr_per_table_interpolator: mismatch");
    end
    $finish;
  end

endmodule
